// ----- hw/rtl/hole_fit_allocator_assert.svh -----
// ----------------------------------------------------------------------------
// Hole fit allocator assertion macros
// Shared concurrent assertion forms used by the RTL of the allocator.
// ----------------------------------------------------------------------------
`ifndef HOLE_FIT_ALLOCATOR_ASSERT_SVH
`define HOLE_FIT_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HFA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HFA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/hfa_pkg.sv -----
// ----------------------------------------------------------------------------
// hfa_pkg
// Types, codes and default sizes for the hole fit allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package hfa_pkg;

    localparam int HOLE_ENTRIES_DEF = 16;
    localparam int SIZE_BITS_DEF    = 16;

    localparam int SIZE_W    = 16;  // size_value / hole_remaining port width
    localparam int INDEX_W   = 4;   // hole_index port width
    localparam int COUNT_W   = 5;   // hole_count / hole_number width
    localparam int REQ_CNT_W = 16;  // request_number width
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIT_MODE   = 1'b0,
        CFG_HOLE_COUNT = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_ALLOC = 1'b1
    } t_op;

    typedef enum logic {
        FIT_FIRST = 1'b0,
        FIT_BEST  = 1'b1
    } t_fit;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_LOAD  = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_WRITE = 4'b1000
    } t_state;

endpackage

`default_nettype wire

// ----- hw/rtl/hole_fit_allocator.sv -----
// ----------------------------------------------------------------------------
// hole_fit_allocator
// First-fit / best-fit allocator over a table of free-hole sizes.
// ----------------------------------------------------------------------------
//
//  channel   signals                                  direction
//  --------  ---------------------------------------  ---------
//  request   i_req_valid / o_req_ready + item fields  in
//  response  o_rsp_valid / i_rsp_ready + result       out
//  config    i_cfg_wr_en, i_cfg_index, i_cfg_wdata    in
//
//  A load request passes through ST_LOAD, which writes the indexed hole and registers
//  the result. An allocate request scans active = min(hole_count, HOLE_ENTRIES)
//  entries in ST_SCAN (none when no hole is in use), then ST_WRITE when granted.
//  One comparator walks the hole RAM entry by entry behind its registered
//  read port, then writes back.
//  One request at a time: o_req_ready is low while a request is in work or a
//  result waits. Reset is synchronous; the hole table reads as zero after it.
//
`default_nettype none

`include "hole_fit_allocator_assert.svh"

module hole_fit_allocator #(
    parameter int HOLE_ENTRIES = hfa_pkg::HOLE_ENTRIES_DEF,
    parameter int SIZE_BITS    = hfa_pkg::SIZE_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [hfa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [hfa_pkg::CFG_DAT_W-1:0] i_cfg_wdata,
    // request
    input  wire logic                          i_req_valid,
    output logic                               o_req_ready,
    input  wire logic                          i_operation,
    input  wire logic [hfa_pkg::INDEX_W-1:0]   i_hole_index,
    input  wire logic [hfa_pkg::SIZE_W-1:0]    i_size_value,
    input  wire logic                          i_final_item,
    // response
    output logic                               o_rsp_valid,
    input  wire logic                          i_rsp_ready,
    output logic                               o_granted,
    output logic      [hfa_pkg::COUNT_W-1:0]   o_hole_number,
    output logic      [hfa_pkg::SIZE_W-1:0]    o_hole_remaining,
    output logic      [hfa_pkg::REQ_CNT_W-1:0] o_request_number,
    output logic                               o_final_result
);

    import hfa_pkg::*;

    localparam int ADDR_W = (HOLE_ENTRIES > 1) ? $clog2(HOLE_ENTRIES) : 1;
    localparam logic [COUNT_W-1:0] ENT_CLAMP =
        (HOLE_ENTRIES > 31) ? COUNT_W'(31) : COUNT_W'(HOLE_ENTRIES);
    localparam logic [REQ_CNT_W-1:0] REQ_MAX = '1;

    // configuration
    logic                 r_fit_mode;
    logic [COUNT_W-1:0]   r_hole_count;

    // latched request
    logic                 r_op;
    logic [INDEX_W-1:0]   r_idx;
    logic [SIZE_BITS-1:0] r_sz;
    logic                 r_fin;

    // sequencer and scan state
    t_state               r_state, n_state;
    logic [REQ_CNT_W-1:0] r_req_cnt, n_req_cnt;
    logic [COUNT_W-1:0]   r_active, n_active;
    logic [COUNT_W-1:0]   r_scan, n_scan;
    logic                 r_cmp_vld, n_cmp_vld;
    logic [COUNT_W-1:0]   r_cmp_idx, n_cmp_idx;
    logic                 r_rd_vbit;
    logic                 r_found, n_found;
    logic [COUNT_W-1:0]   r_pick, n_pick;
    logic [SIZE_BITS-1:0] r_best, n_best;
    logic [HOLE_ENTRIES-1:0] r_valid;

    // result register
    logic                 r_out_valid, n_out_valid;
    logic                 r_out_granted, n_out_granted;
    logic [COUNT_W-1:0]   r_out_hole_num, n_out_hole_num;
    logic [SIZE_W-1:0]    r_out_remain, n_out_remain;
    logic [REQ_CNT_W-1:0] r_out_req_num, n_out_req_num;
    logic                 r_out_final, n_out_final;

    logic                 w_req_acc;
    logic [31:0]          w_sz_ext;
    logic [SIZE_BITS-1:0] w_sz_in;
    logic                 w_idx_ok;
    logic [COUNT_W-1:0]   w_cnt_clamped;
    logic [ADDR_W-1:0]    w_raddr;
    logic [31:0]          w_raddr_ext;
    logic                 w_ram_we;
    logic [COUNT_W-1:0]   w_waddr_c;
    logic [31:0]          w_waddr_ext;
    logic [ADDR_W-1:0]    w_waddr;
    logic [SIZE_BITS-1:0] w_wdata;
    logic [SIZE_BITS-1:0] w_rdata;
    logic [SIZE_BITS-1:0] w_hole;
    logic [SIZE_BITS-1:0] w_diff;
    logic [31:0]          w_diff_ext;
    logic                 w_fit;
    logic                 w_better;
    logic                 w_take;

    assign w_req_acc = i_req_valid & o_req_ready;

    assign w_sz_ext = {16'b0, i_size_value};
    assign w_sz_in  = w_sz_ext[SIZE_BITS-1:0];
    assign w_idx_ok = (32'(r_idx) < HOLE_ENTRIES);

    assign w_cnt_clamped = (32'(r_hole_count) > HOLE_ENTRIES) ? ENT_CLAMP : r_hole_count;

    assign w_raddr_ext = 32'(r_scan);
    assign w_raddr     = w_raddr_ext[ADDR_W-1:0];
    assign w_waddr_ext = 32'(w_waddr_c);
    assign w_waddr     = w_waddr_ext[ADDR_W-1:0];

    // shared compare unit: an entry never written reads as zero
    assign w_hole   = r_rd_vbit ? w_rdata : '0;
    assign w_fit    = (w_hole >= r_sz);
    assign w_better = !r_found || ((r_fit_mode == FIT_BEST) && (w_hole < r_best));
    assign w_take   = r_cmp_vld && w_fit && w_better;

    assign w_diff     = r_best - r_sz;
    assign w_diff_ext = 32'(w_diff);

    hfa_ram #(
        .WIDTH  (SIZE_BITS),
        .DEPTH  (HOLE_ENTRIES),
        .ADDR_W (ADDR_W)
    ) u_hole_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state        = r_state;
        n_req_cnt      = r_req_cnt;
        n_active       = r_active;
        n_scan         = r_scan;
        n_cmp_vld      = 1'b0;
        n_cmp_idx      = r_cmp_idx;
        n_found        = r_found;
        n_pick         = r_pick;
        n_best         = r_best;
        n_out_valid    = r_out_valid & ~i_rsp_ready;
        n_out_granted  = r_out_granted;
        n_out_hole_num = r_out_hole_num;
        n_out_remain   = r_out_remain;
        n_out_req_num  = r_out_req_num;
        n_out_final    = r_out_final;
        w_ram_we       = 1'b0;
        w_waddr_c      = {1'b0, r_idx};
        w_wdata        = r_sz;

        case (r_state)
            ST_IDLE: begin
                if (w_req_acc) begin
                    n_scan   = '0;
                    n_found  = 1'b0;
                    n_active = w_cnt_clamped;
                    if (i_operation == OP_LOAD) begin
                        n_req_cnt = '0;
                        n_state   = ST_LOAD;
                    end else begin
                        if (r_req_cnt != REQ_MAX) begin
                            n_req_cnt = r_req_cnt + 1'b1;
                        end
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_LOAD: begin
                w_ram_we       = w_idx_ok;
                n_out_valid    = 1'b1;
                n_out_granted  = 1'b0;
                n_out_hole_num = '0;
                n_out_remain   = '0;
                n_out_req_num  = '0;
                n_out_final    = r_fin;
                n_state        = ST_IDLE;
            end
            ST_SCAN: begin
                // issue the next read while comparing the previous one
                if (r_scan != r_active) begin
                    n_scan    = r_scan + 1'b1;
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_scan;
                end
                if (w_take) begin
                    n_found = 1'b1;
                    n_pick  = r_cmp_idx;
                    n_best  = w_hole;
                end
                if ((r_scan == r_active) && !r_cmp_vld) begin
                    if (r_found) begin
                        n_state = ST_WRITE;
                    end else begin
                        n_out_valid    = 1'b1;
                        n_out_granted  = 1'b0;
                        n_out_hole_num = '0;
                        n_out_remain   = '0;
                        n_out_req_num  = r_req_cnt;
                        n_out_final    = r_fin;
                        n_state        = ST_IDLE;
                    end
                end
            end
            ST_WRITE: begin
                // shrink the chosen hole
                w_ram_we       = 1'b1;
                w_waddr_c      = r_pick;
                w_wdata        = w_diff;
                n_out_valid    = 1'b1;
                n_out_granted  = 1'b1;
                n_out_hole_num = r_pick + 1'b1;
                n_out_remain   = w_diff_ext[SIZE_W-1:0];
                n_out_req_num  = r_req_cnt;
                n_out_final    = r_fin;
                n_state        = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_mode   <= FIT_FIRST;
            r_hole_count <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_FIT_MODE:   r_fit_mode   <= i_cfg_wdata[0];
                CFG_HOLE_COUNT: r_hole_count <= i_cfg_wdata;
                default: begin
                    r_fit_mode <= r_fit_mode;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_req_cnt   <= '0;
            r_scan      <= '0;
            r_active    <= '0;
            r_cmp_vld   <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
            r_valid     <= '0;
        end else begin
            r_state     <= n_state;
            r_req_cnt   <= n_req_cnt;
            r_scan      <= n_scan;
            r_active    <= n_active;
            r_cmp_vld   <= n_cmp_vld;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
            if (w_ram_we) begin
                r_valid[w_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_req_acc) begin
            r_op  <= i_operation;
            r_idx <= i_hole_index;
            r_sz  <= w_sz_in;
            r_fin <= i_final_item;
        end
        r_rd_vbit      <= r_valid[w_raddr];
        r_cmp_idx      <= n_cmp_idx;
        r_pick         <= n_pick;
        r_best         <= n_best;
        r_out_granted  <= n_out_granted;
        r_out_hole_num <= n_out_hole_num;
        r_out_remain   <= n_out_remain;
        r_out_req_num  <= n_out_req_num;
        r_out_final    <= n_out_final;
    end

    assign o_req_ready      = (r_state == ST_IDLE) && !r_out_valid;
    assign o_rsp_valid      = r_out_valid;
    assign o_granted        = r_out_granted;
    assign o_hole_number    = r_out_hole_num;
    assign o_hole_remaining = r_out_remain;
    assign o_request_number = r_out_req_num;
    assign o_final_result   = r_out_final;

    `HFA_ASSERT_IMP(a_refused_clean, i_clk, i_rst_n,
        o_rsp_valid && !o_granted,
        o_hole_number == 5'd0 && o_hole_remaining == 16'd0,
        "refused result carries hole fields")
    `HFA_ASSERT_IMP(a_grant_numbered, i_clk, i_rst_n,
        o_rsp_valid && o_granted,
        o_hole_number != 5'd0 && o_request_number != 16'd0,
        "grant without hole or request number")
    `HFA_ASSERT_NXT(a_no_instant_rsp, i_clk, i_rst_n,
        i_req_valid && o_req_ready,
        !o_rsp_valid && !o_req_ready,
        "result or ready right after accept")
    `HFA_ASSERT_IMP(a_scan_bound, i_clk, i_rst_n,
        r_state == ST_SCAN,
        r_scan <= r_active && r_op == OP_ALLOC,
        "scan past active holes or on a load")

endmodule

`default_nettype wire

// ----- hw/rtl/hfa_ram.sv -----
// ----------------------------------------------------------------------------
// hfa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hfa_ram #(
    parameter int WIDTH = hfa_pkg::SIZE_BITS_DEF,
    parameter int DEPTH = hfa_pkg::HOLE_ENTRIES_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire
